### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/phm_pkg.sv
`timescale 1ns / 1ps

package phm_pkg;

   localparam int PAL_N     = 7;
   localparam int CH_W      = 8;
   localparam int HUE_W     = 12;
   localparam int SAT_W     = 8;
   localparam int POS_W     = 12;
   localparam int IDX_W     = 3;
   localparam int RGB_W     = 24;
   localparam int DIST_W    = 21;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 40;
   // hsv converter: two front stages plus one stage per hue quotient bit
   localparam int CVT_LAT   = 15;
   localparam int MATCH_LAT = 4;
   localparam int PIPE_LAT  = CVT_LAT + MATCH_LAT;
   localparam int BUSY_W    = $clog2(CVT_LAT + 1);

   localparam logic [CH_W-1:0] DARK_RESET = 8'd20;

   typedef enum logic [2:0] {
      REG_PAL0,
      REG_PAL1,
      REG_PAL2,
      REG_PAL3,
      REG_PAL4,
      REG_PAL5,
      REG_PAL6,
      REG_DARK
   } reg_idx_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [SAT_W-1:0] sat;
   } hs_type;

   typedef hs_type [PAL_N-1:0] pal_hs_type;

   typedef struct packed {
      logic            busy;
      logic [CH_W-1:0] dark_threshold;
   } cfg_type;

   function automatic logic [CH_W-1:0] max3(input logic [CH_W-1:0] a,
                                            input logic [CH_W-1:0] b,
                                            input logic [CH_W-1:0] c);
      logic [CH_W-1:0] m;
      m = (a > b) ? a : b;
      return (m > c) ? m : c;
   endfunction

endpackage

### hw/rtl/phm_hsv.sv
`timescale 1ns / 1ps

module phm_hsv import phm_pkg::*; (
   input  logic            clock,
   input  logic            enable,
   input  logic [CH_W-1:0] red,
   input  logic [CH_W-1:0] green,
   input  logic [CH_W-1:0] blue,
   output hs_type          hs
);

   localparam int HQ_W = HUE_W + 1;        // hue quotient reaches a full turn
   localparam int HD_W = CH_W + 3;         // 6*c
   localparam int HN_W = HD_W + HUE_W;     // 4096*t + 3*c
   localparam int SQ_W = SAT_W;
   localparam int SD_W = CH_W;
   localparam int SN_W = 2 * CH_W + 1;     // 255*c + mx/2
   localparam int T_W  = HD_W + 1;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef struct packed {
      logic            zero;
      logic [HN_W-1:0] rem_h;
      logic [HD_W-1:0] div_h;
      logic [HQ_W-1:0] quo_h;
      logic [SN_W-1:0] rem_s;
      logic [SD_W-1:0] div_s;
      logic [SQ_W-1:0] quo_s;
   } div_type;

   // front stage 1: max, chroma, sector
   logic [CH_W-1:0]        mx_in, mx_ff, mn_in, c_in, c_ff;
   max_sel_type            sel_in, sel_ff;
   logic signed [CH_W:0]   d_in, d_ff;

   // front stage 2 and divider steps
   div_type                div0_in;
   div_type                div_ff [0:HQ_W];
   div_type                div_in [1:HQ_W];

   always_comb begin
      mx_in = max3(red, green, blue);
      mn_in = red;
      if (green < mn_in) mn_in = green;
      if (blue < mn_in) mn_in = blue;
      c_in = mx_in - mn_in;
      if (mx_in == red) begin
         sel_in = MAX_RED;
         d_in   = signed'({1'b0, green}) - signed'({1'b0, blue});
      end else if (mx_in == green) begin
         sel_in = MAX_GREEN;
         d_in   = signed'({1'b0, blue}) - signed'({1'b0, red});
      end else begin
         sel_in = MAX_BLUE;
         d_in   = signed'({1'b0, red}) - signed'({1'b0, green});
      end
   end

   always_comb begin
      logic [CH_W+1:0]      base;
      logic [CH_W+1:0]      c3;
      logic [HD_W-1:0]      c6;
      logic signed [T_W-1:0] t_raw;
      logic signed [T_W-1:0] t_val;
      case (sel_ff)
         MAX_RED:   base = '0;
         MAX_GREEN: base = {1'b0, c_ff, 1'b0};
         MAX_BLUE:  base = {c_ff, 2'b00};
         default:   base = '0;
      endcase
      c3    = {2'b00, c_ff} + {1'b0, c_ff, 1'b0};
      c6    = HD_W'({c_ff, 2'b00}) + HD_W'({c_ff, 1'b0});
      t_raw = signed'(T_W'(base)) + T_W'(d_ff);
      if (t_raw < 0) t_val = t_raw + signed'(T_W'(c6));
      else t_val = t_raw;
      div0_in.zero  = (c_ff == '0);
      div0_in.rem_h = {t_val[HD_W-1:0], {HUE_W{1'b0}}} + HN_W'(c3);
      div0_in.div_h = c6;
      div0_in.quo_h = '0;
      div0_in.rem_s = SN_W'({c_ff, {CH_W{1'b0}}}) - SN_W'(c_ff) + SN_W'(mx_ff >> 1);
      div0_in.div_s = mx_ff;
      div0_in.quo_s = '0;
   end

   // restoring division: a hue bit per stage, a sat bit per stage up to SQ_W
   always_comb begin
      logic [HN_W-1:0] sh_h;
      logic [SN_W-1:0] sh_s;
      for (int s = 1; s <= HQ_W; s++) begin
         div_in[s] = div_ff[s-1];
         sh_h = HN_W'(div_ff[s-1].div_h) << (HQ_W - s);
         if (div_ff[s-1].rem_h >= sh_h) begin
            div_in[s].rem_h           = div_ff[s-1].rem_h - sh_h;
            div_in[s].quo_h[HQ_W - s] = 1'b1;
         end
         sh_s = '0;
         if (s <= SQ_W) begin
            sh_s = SN_W'(div_ff[s-1].div_s) << (SQ_W - s);
            if (div_ff[s-1].rem_s >= sh_s) begin
               div_in[s].rem_s           = div_ff[s-1].rem_s - sh_s;
               div_in[s].quo_s[SQ_W - s] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mx_ff     <= mx_in;
         c_ff      <= c_in;
         sel_ff    <= sel_in;
         d_ff      <= d_in;
         div_ff[0] <= div0_in;
         for (int s = 1; s <= HQ_W; s++) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // grey: hue and saturation forced to zero; a full turn wraps to hue 0
   assign hs.hue = div_ff[HQ_W].zero ? '0 : div_ff[HQ_W].quo_h[HUE_W-1:0];
   assign hs.sat = div_ff[HQ_W].zero ? '0 : div_ff[HQ_W].quo_s;

endmodule

### hw/rtl/phm_match.sv
`timescale 1ns / 1ps

module phm_match import phm_pkg::*; (
   input  logic             clock,
   input  logic             enable,
   input  hs_type           pix_hs,
   input  pal_hs_type       pal_hs,
   output logic [IDX_W-1:0] color_index
);

   localparam int DH_W = HUE_W + 2;
   localparam logic signed [DH_W-1:0] HUE_HALF = DH_W'(1 << (HUE_W - 1));
   localparam logic signed [DH_W-1:0] HUE_TURN = DH_W'(1 << HUE_W);
   localparam int CAND_N = (PAL_N + 1) / 2;

   typedef struct packed {
      logic [DIST_W-1:0] cost;
      logic [IDX_W-1:0]  idx;
   } cand_type;

   function automatic cand_type pick(input cand_type a, input cand_type b);
      return (b.cost < a.cost) ? b : a;
   endfunction

   logic [HUE_W-1:0]  adh_in  [PAL_N];
   logic [HUE_W-1:0]  adh_ff  [PAL_N];
   logic [SAT_W-1:0]  ads_in  [PAL_N];
   logic [SAT_W-1:0]  ads_ff  [PAL_N];
   logic [SAT_W-1:0]  ps_ff;
   logic [DIST_W-1:0] dist_in [PAL_N];
   logic [DIST_W-1:0] dist_ff [PAL_N];
   cand_type          cand_in [CAND_N];
   cand_type          cand_ff [CAND_N];
   logic [IDX_W-1:0]  idx_in, idx_ff;

   // hue difference wrapped to half a turn, then magnitudes
   always_comb begin
      logic signed [DH_W-1:0]  dh;
      logic signed [SAT_W:0]   ds;
      for (int i = 0; i < PAL_N; i++) begin
         dh = signed'(DH_W'(pix_hs.hue)) - signed'(DH_W'(pal_hs[i].hue));
         if (dh > HUE_HALF) dh = dh - HUE_TURN;
         if (dh < -HUE_HALF) dh = dh + HUE_TURN;
         if (dh < 0) dh = -dh;
         adh_in[i] = dh[HUE_W-1:0];
         ds = signed'({1'b0, pix_hs.sat}) - signed'({1'b0, pal_hs[i].sat});
         if (ds < 0) ds = -ds;
         ads_in[i] = ds[SAT_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < PAL_N; i++) begin
         dist_in[i] = DIST_W'(adh_ff[i]) * DIST_W'(ps_ff)
                    + (DIST_W'(ads_ff[i]) << HUE_W);
      end
   end

   // first tree level: neighbouring pairs, lower index first so it keeps ties
   always_comb begin
      for (int j = 0; j < CAND_N; j++) begin
         if (2 * j + 1 < PAL_N) begin
            cand_in[j] = pick('{cost: dist_ff[2*j],   idx: IDX_W'(2 * j)},
                              '{cost: dist_ff[2*j+1], idx: IDX_W'(2 * j + 1)});
         end else begin
            cand_in[j] = '{cost: dist_ff[2*j], idx: IDX_W'(2 * j)};
         end
      end
   end

   always_comb begin
      cand_type best;
      best = cand_ff[0];
      for (int j = 1; j < CAND_N; j++) begin
         best = pick(best, cand_ff[j]);
      end
      idx_in = best.idx;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         ps_ff  <= pix_hs.sat;
         for (int i = 0; i < PAL_N; i++) begin
            adh_ff[i]  <= adh_in[i];
            ads_ff[i]  <= ads_in[i];
            dist_ff[i] <= dist_in[i];
         end
         for (int j = 0; j < CAND_N; j++) begin
            cand_ff[j] <= cand_in[j];
         end
         idx_ff <= idx_in;
      end
   end

   assign color_index = idx_ff;

endmodule

### hw/rtl/phm_csr.sv
`timescale 1ns / 1ps

module phm_csr import phm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg,
   output pal_hs_type        pal_hs
);

   reg_idx_type          reg_idx;
   logic [IDX_W-1:0]     pal_sel;
   logic                 wr, pal_wr;
   logic [RGB_W-1:0]     pal_ff [PAL_N];
   logic [CH_W-1:0]      dark_ff;
   pal_hs_type           pal_hs_ff;
   hs_type               cvt_hs;
   logic [CVT_LAT-1:0]   tag_vld_ff;
   logic [IDX_W-1:0]     tag_idx_ff [CVT_LAT];
   logic [BUSY_W-1:0]    busy_ff;

   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[ADDR_W-1:2]);
   assign pal_sel    = csr_paddr[ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign pal_wr     = wr && (reg_idx != REG_DARK);

   always_comb begin
      case (reg_idx)
         REG_DARK: csr_prdata = DATA_W'(dark_ff);
         default:  csr_prdata = DATA_W'(pal_ff[pal_sel]);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAL_N; i++) pal_ff[i] <= '0;
         dark_ff <= DARK_RESET;
      end else if (wr) begin
         if (reg_idx == REG_DARK) dark_ff <= csr_pwdata[CH_W-1:0];
         else pal_ff[pal_sel] <= csr_pwdata[RGB_W-1:0];
      end
   end

   // palette hue/sat worked out once per write by a converter of its own
   phm_hsv u_hsv (
      .clock  (clock),
      .enable (1'b1),
      .red    (csr_pwdata[3*CH_W-1:2*CH_W]),
      .green  (csr_pwdata[2*CH_W-1:CH_W]),
      .blue   (csr_pwdata[CH_W-1:0]),
      .hs     (cvt_hs)
   );

   always_ff @(posedge clock) begin
      tag_idx_ff[0] <= pal_sel;
      for (int s = 1; s < CVT_LAT; s++) tag_idx_ff[s] <= tag_idx_ff[s-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff <= '0;
         pal_hs_ff  <= '0;
         busy_ff    <= '0;
      end else begin
         tag_vld_ff <= {tag_vld_ff[CVT_LAT-2:0], pal_wr};
         if (tag_vld_ff[CVT_LAT-1]) begin
            for (int i = 0; i < PAL_N; i++) begin
               if (tag_idx_ff[CVT_LAT-1] == IDX_W'(i)) pal_hs_ff[i] <= cvt_hs;
            end
         end
         if (pal_wr) busy_ff <= BUSY_W'(CVT_LAT);
         else if (busy_ff != '0) busy_ff <= busy_ff - 1'b1;
      end
   end

   assign cfg.busy           = (busy_ff != '0);
   assign cfg.dark_threshold = dark_ff;
   assign pal_hs             = pal_hs_ff;

endmodule

### hw/rtl/pixel_hsv_palette_matcher.sv
// Pixel to palette matcher in hue/saturation space.
// req_* carries one pixel per beat (red, green, blue, column, row). A pixel
// whose channels all stay at or below the dark threshold is dropped; every
// other pixel yields one rsp_* beat with the nearest palette index (lower
// index on ties), its largest channel as intensity, its position and an
// odd-row half-shift flag.
// From an accepted req beat to rsp_tvalid a pixel passes 15 stages of
// hue/saturation conversion (two front stages, then one restoring-divide bit
// per stage) and 4 stages of distance, multiply and a two-level minimum tree.
// One pixel per cycle unless stalled: while rsp_tvalid waits on rsp_tready
// the whole pipeline holds and req_tready drops; nothing is lost or repeated.
// csr_* is an APB-style register port: palette entries 0..6 at 0x00..0x18,
// dark threshold at 0x1c. Each palette write is converted by a dedicated
// converter, so req_tready stays low while that conversion is in flight.
// Reset empties the pipeline, clears the palette to black and sets the dark
// threshold to 20.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pixel_hsv_palette_matcher import phm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // red_level, green_level, blue_level, pixel_column, pixel_row
   input  logic [REQ_W-1:0]  req_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // cell_column, cell_row, half_shift, color_index, intensity, zero pad
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [CH_W-1:0]     red, green, blue;
   logic [POS_W-1:0]    col, row;
   logic                bright, adv, take;
   logic                pal_write;
   cfg_type             cfg;
   pal_hs_type          pal_hs;
   hs_type              pix_hs;
   logic [IDX_W-1:0]    color_index;
   logic [PIPE_LAT-1:0] vld_ff;
   logic [POS_W-1:0]    col_ff [PIPE_LAT];
   logic [POS_W-1:0]    row_ff [PIPE_LAT];
   logic [CH_W-1:0]     mx_ff  [PIPE_LAT];

   assign red   = req_tdata[CH_W-1:0];
   assign green = req_tdata[2*CH_W-1:CH_W];
   assign blue  = req_tdata[3*CH_W-1:2*CH_W];
   assign col   = req_tdata[3*CH_W+POS_W-1:3*CH_W];
   assign row   = req_tdata[3*CH_W+2*POS_W-1:3*CH_W+POS_W];

   assign bright = (red > cfg.dark_threshold) || (green > cfg.dark_threshold)
                || (blue > cfg.dark_threshold);

   // the whole pipeline moves together unless the output beat is held
   assign adv        = !vld_ff[PIPE_LAT-1] || rsp_tready;
   assign req_tready = adv && !cfg.busy;
   assign take       = req_tvalid && req_tready && bright;

   assign pal_write = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[ADDR_W-1:2] != REG_DARK);

   phm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .pal_hs      (pal_hs)
   );

   phm_hsv u_hsv (
      .clock  (clock),
      .enable (adv),
      .red    (red),
      .green  (green),
      .blue   (blue),
      .hs     (pix_hs)
   );

   phm_match u_match (
      .clock       (clock),
      .enable      (adv),
      .pix_hs      (pix_hs),
      .pal_hs      (pal_hs),
      .color_index (color_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         col_ff[0] <= col;
         row_ff[0] <= row;
         mx_ff[0]  <= max3(red, green, blue);
         for (int s = 1; s < PIPE_LAT; s++) begin
            col_ff[s] <= col_ff[s-1];
            row_ff[s] <= row_ff[s-1];
            mx_ff[s]  <= mx_ff[s-1];
         end
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_LAT-1];
   assign rsp_tdata  = RSP_W'({mx_ff[PIPE_LAT-1], color_index, row_ff[PIPE_LAT-1][0],
                               row_ff[PIPE_LAT-1], col_ff[PIPE_LAT-1]});

   `ASSERT_NEXT(a_pal_write_blocks, clock, reset, pal_write, !req_tready)
   `ASSERT_NEXT(a_stall_freezes, clock, reset, !adv, $stable(vld_ff))
   `ASSERT_NEXT(a_bright_enters, clock, reset, take, vld_ff[0])
   `ASSERT_IMPLIES(a_index_range, clock, reset, rsp_tvalid, color_index < IDX_W'(PAL_N))

endmodule

### sim/tb_pixel_hsv_palette_matcher.sv
`timescale 1ns / 1ps

module tb_pixel_hsv_palette_matcher import phm_pkg::*; ();

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = PIPE_LAT + 8;
   localparam int REPORT_MAX    = 10;
   localparam int DIRECTED_N    = 22;
   localparam int PHASE_N       = 7;

   typedef struct {
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             half;
      logic [IDX_W-1:0] index;
      logic [CH_W-1:0]  level;
   } cell_type;

   typedef struct packed {
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             typed;
      logic             kept;
      logic [IDX_W-1:0] index;
      logic [CH_W-1:0]  level;
   } pixel_row_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   // red_level, green_level, blue_level, pixel_column, pixel_row
   logic [REQ_W-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   // cell_column, cell_row, half_shift, color_index, intensity, zero pad
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   // mirror of the register file
   logic [RGB_W-1:0]  palette [PAL_N];
   logic [CH_W-1:0]   dark_level;
   logic [RGB_W-1:0]  plan_palette [PAL_N];
   logic [CH_W-1:0]   plan_dark;

   pixel_row_type     directed_pixels [DIRECTED_N];
   cell_type          expected_cells [$];

   int req_idle_pct = 25;
   int rsp_idle_pct = 25;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int pixels_sent = 0;
   int pixels_kept = 0;
   int cells_seen = 0;
   int settings_used = 0;

   pixel_hsv_palette_matcher i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_count,
                  expected_cells.size());
         $display("tb_pixel_hsv_palette_matcher NOT OK");
         $finish;
      end
   end

   function automatic hs_type hue_sat_of(logic [RGB_W-1:0] rgb);
      int r, g, b, hi, lo, span, t;
      hs_type hs;
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      hs = '0;
      if (span == 0) return hs;
      // sector chosen by the largest channel, red taking priority on ties
      if (hi == r) t = g - b;
      else if (hi == g) t = 2 * span + b - r;
      else t = 4 * span + r - g;
      if (t < 0) t += 6 * span;
      hs.hue = HUE_W'((4096 * t + 3 * span) / (6 * span));
      hs.sat = SAT_W'((255 * span + hi / 2) / hi);
      return hs;
   endfunction

   function automatic bit predict_cell(logic [REQ_W-1:0] pix, output cell_type res);
      logic [CH_W-1:0] r, g, b;
      hs_type px, pe;
      int dh, ds, cost, best;
      r = pix[7:0];
      g = pix[15:8];
      b = pix[23:16];
      res.column = pix[35:24];
      res.row = pix[47:36];
      res.half = pix[36];
      res.index = '0;
      res.level = r;
      if (g > res.level) res.level = g;
      if (b > res.level) res.level = b;
      if (r <= dark_level && g <= dark_level && b <= dark_level) return 1'b0;
      px = hue_sat_of({r, g, b});
      best = 0;
      for (int i = 0; i < PAL_N; i++) begin
         pe = hue_sat_of(palette[i]);
         dh = int'(px.hue) - int'(pe.hue);
         if (dh > 2048) dh -= 4096;
         if (dh < -2048) dh += 4096;
         if (dh < 0) dh = -dh;
         ds = int'(px.sat) - int'(pe.sat);
         if (ds < 0) ds = -ds;
         cost = dh * int'(px.sat) + 4096 * ds;
         if (i == 0 || cost < best) begin
            best = cost;
            res.index = IDX_W'(i);
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [REQ_W-1:0] pack_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                                   logic [CH_W-1:0] b,
                                                   logic [POS_W-1:0] col,
                                                   logic [POS_W-1:0] row);
      return {row, col, b, g, r};
   endfunction

   function automatic logic [CH_W-1:0] near(logic [CH_W-1:0] x, int spread);
      int v;
      v = int'(x) + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return CH_W'(v);
   endfunction

   function automatic logic [REQ_W-1:0] random_pixel();
      logic [CH_W-1:0] r, g, b;
      logic [RGB_W-1:0] base;
      r = CH_W'($urandom);
      g = CH_W'($urandom);
      b = CH_W'($urandom);
      case ($urandom_range(0, 9))
         4: begin
            g = r;
            b = r;
         end
         5: begin
            base = palette[$urandom_range(0, PAL_N - 1)];
            r = near(base[23:16], 4);
            g = near(base[15:8], 4);
            b = near(base[7:0], 4);
         end
         6: begin
            // two channels made equal
            if ($urandom_range(0, 1)) g = r;
            else b = g;
         end
         7: begin
            r = near(dark_level, 1);
            g = near(dark_level, 1);
            b = near(dark_level, 1);
         end
         8: begin
            r = 8'hFF;
            g = 8'h00;
            repeat ($urandom_range(0, 2)) {r, g, b} = {b, r, g};
            if ($urandom_range(0, 1)) {r, g} = {g, r};
         end
         9: begin
            r = {CH_W{1'($urandom)}};
            g = {CH_W{1'($urandom)}};
            b = {CH_W{1'($urandom)}};
         end
         default: ;
      endcase
      return pack_pixel(r, g, b, POS_W'($urandom), POS_W'($urandom));
   endfunction

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want,
                     got);
      end
   endtask

   task automatic check_cell(logic [RSP_W-1:0] beat);
      cell_type want;
      cells_seen++;
      if (expected_cells.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: unexpected rsp beat 0x%0h", $realtime, beat);
      end else begin
         want = expected_cells.pop_front();
         check_field("cell_column", beat[11:0], want.column);
         check_field("cell_row", beat[23:12], want.row);
         check_field("half_shift", beat[24], want.half);
         check_field("color_index", beat[27:25], want.index);
         check_field("intensity", beat[35:28], want.level);
      end
   endtask

   // result side: stalls, the long hold-off and the checker
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_cell(rsp_tdata);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic note_cell(cell_type c);
      expected_cells.push_back(c);
      pixels_kept++;
   endtask

   // returns with req_tvalid still high so back-to-back beats need no re-raise
   task automatic send_pixel(logic [REQ_W-1:0] pix);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_cells.size() != 0) @(posedge clock);
      // dark pixels leave no trace in the queue but may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_idx_type idx, logic [DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_W'(4 * int'(idx));
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_DARK) dark_level = value[CH_W-1:0];
      else palette[idx] = value[RGB_W-1:0];
      @(posedge clock);
   endtask

   task automatic check_registers();
      reg_idx_type idx;
      logic [DATA_W-1:0] want;
      for (int i = 0; i <= int'(REG_DARK); i++) begin
         idx = reg_idx_type'(i);
         want = (idx == REG_DARK) ? DATA_W'(dark_level) : DATA_W'(palette[idx]);
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b0;
         csr_paddr <= ADDR_W'(4 * i);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         check_field($sformatf("register %s readback", idx.name()), csr_prdata, want);
         csr_psel <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
      end
   endtask

   // junk above the register width must be dropped
   task automatic apply_settings();
      for (int i = 0; i < PAL_N; i++)
         csr_write(reg_idx_type'(i), {8'($urandom), plan_palette[i]});
      csr_write(REG_DARK, {24'($urandom), plan_dark});
      check_registers();
      settings_used++;
   endtask

   task automatic run_directed(int first, int last);
      cell_type want;
      logic [REQ_W-1:0] pix;
      for (int i = first; i <= last; i++) begin
         pix = pack_pixel(directed_pixels[i].red, directed_pixels[i].green,
                          directed_pixels[i].blue, directed_pixels[i].column,
                          directed_pixels[i].row);
         send_pixel(pix);
         if (directed_pixels[i].typed) begin
            if (directed_pixels[i].kept) begin
               want.column = directed_pixels[i].column;
               want.row = directed_pixels[i].row;
               want.half = directed_pixels[i].row[0];
               want.index = directed_pixels[i].index;
               want.level = directed_pixels[i].level;
               note_cell(want);
            end
         end else if (predict_cell(pix, want)) begin
            note_cell(want);
         end
      end
   endtask

   // stops after target kept pixels, or a cap when the threshold drops most
   task automatic send_batch(int target);
      cell_type want;
      logic [REQ_W-1:0] pix;
      int kept, sent;
      kept = 0;
      sent = 0;
      while (kept < target && sent < 10 * target) begin
         pix = random_pixel();
         send_pixel(pix);
         sent++;
         if (predict_cell(pix, want)) begin
            note_cell(want);
            kept++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (int i = 0; i < PAL_N; i++) palette[i] = '0;
      dark_level = DARK_RESET;

      // red, green, blue, column, row, typed, kept, index, intensity
      directed_pixels = '{
         // reset palette is all black, so every kept pixel ties onto entry 0
         '{8'd0,   8'd0,   8'd0,   12'd0,    12'd0,    1'b1, 1'b0, 3'd0, 8'd0},
         '{8'd20,  8'd20,  8'd20,  12'd7,    12'd3,    1'b1, 1'b0, 3'd0, 8'd0},
         '{8'd21,  8'd0,   8'd0,   12'd4095, 12'd4095, 1'b1, 1'b1, 3'd0, 8'd21},
         '{8'd0,   8'd0,   8'd21,  12'd0,    12'd1,    1'b1, 1'b1, 3'd0, 8'd21},
         '{8'd255, 8'd255, 8'd255, 12'd4095, 12'd0,    1'b1, 1'b1, 3'd0, 8'd255},
         '{8'd0,   8'd255, 8'd0,   12'd2730, 12'd1365, 1'b1, 1'b1, 3'd0, 8'd255},
         '{8'd19,  8'd20,  8'd18,  12'd100,  12'd200,  1'b1, 1'b0, 3'd0, 8'd0},
         // primaries, secondaries, grey, hue wrap and max-channel ties
         '{8'd255, 8'd0,   8'd0,   12'd1,    12'd2,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd0,   8'd255, 8'd0,   12'd2,    12'd3,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd0,   8'd0,   8'd255, 12'd3,    12'd4,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd255, 8'd0,   12'd4,    12'd5,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd0,   8'd255, 8'd255, 12'd5,    12'd6,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd0,   8'd255, 12'd6,    12'd7,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd255, 8'd255, 12'd7,    12'd8,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd21,  8'd21,  8'd21,  12'd8,    12'd9,    1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd0,   8'd8,   12'd9,    12'd10,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd128, 8'd0,   12'd10,   12'd11,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd200, 8'd100, 8'd50,  12'd11,   12'd12,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd128, 8'd128, 8'd0,   12'd12,   12'd13,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd0,   8'd128, 8'd128, 12'd13,   12'd14,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd255, 8'd0,   8'd128, 12'd14,   12'd15,   1'b0, 1'b0, 3'd0, 8'd0},
         '{8'd21,  8'd20,  8'd20,  12'd15,   12'd16,   1'b0, 1'b0, 3'd0, 8'd0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_registers();
      run_directed(0, 6);

      settle();
      plan_palette = '{24'hFF0000, 24'hFFFF00, 24'h00FF00, 24'h00FFFF, 24'h0000FF,
                       24'hFF00FF, 24'h808080};
      plan_dark = DARK_RESET;
      apply_settings();
      run_directed(7, DIRECTED_N - 1);

      for (int phase = 0; phase < PHASE_N; phase++) begin
         settle();
         req_idle_pct = 25;
         rsp_idle_pct = 25;
         case (phase)
            0, 1, 6: begin
               foreach (plan_palette[i]) plan_palette[i] = RGB_W'($urandom);
               plan_dark = (phase == 6) ? 8'd0 : CH_W'($urandom_range(0, 60));
            end
            2: begin
               foreach (plan_palette[i]) begin
                  plan_palette[i] = {8'hFF, 8'h00, 8'($urandom)};
                  repeat ($urandom_range(0, 2))
                     plan_palette[i] = {plan_palette[i][7:0], plan_palette[i][23:8]};
               end
               plan_dark = 8'd0;
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
            3: begin
               plan_palette = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'hFF0000, 24'h00FF00,
                                24'h0000FF, 24'hFFFFFE};
               plan_dark = 8'd254;
            end
            4: plan_dark = 8'd255;
            5: begin
               // few distinct colours so that equal distances are common
               plan_palette[0] = RGB_W'($urandom);
               plan_palette[1] = RGB_W'($urandom);
               for (int i = 2; i < PAL_N; i++)
                  plan_palette[i] = plan_palette[$urandom_range(0, 1)];
               plan_dark = CH_W'($urandom_range(0, 100));
            end
            default: ;
         endcase
         apply_settings();
         case (phase)
            1: begin
               hold_request = 1'b1;
               send_batch(120);
               settle();
               send_batch(120);
            end
            2: send_batch(300);
            3: send_batch(60);
            4: send_batch(5);
            6: send_batch(200);
            default: send_batch(250);
         endcase
      end
      settle();

      $display("%0d pixels sent (%0d dark), %0d result beats checked, %0d register settings",
               pixels_sent, pixels_sent - pixels_kept, cells_seen, settings_used);
      $display("covered threshold and palette extremes, ties, hue wrap, long output stall");
      if (mismatch_count == 0 && expected_cells.size() == 0)
         $display("tb_pixel_hsv_palette_matcher OK");
      else
         $display("tb_pixel_hsv_palette_matcher NOT OK");
      $finish;
   end

endmodule
